// ----- rtl/core/sm4_block_cipher_assert.svh -----
// Assertion macros shared by the cipher modules; they expect signals clk and rst in scope.
`ifndef SM4_BLOCK_CIPHER_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SM4_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SM4_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SM4_ASSERT_ALWAYS(label, cond, msg)
`define SM4_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/sm4_pkg.sv -----
// Constants, tables and round functions of the SM4 cipher.
`default_nettype none

package sm4_pkg;

  localparam int ROUNDS_DEF = 32;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [31:0] FK [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Byte-wise substitution of a word.
  function automatic logic [31:0] tau(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Linear transform of the data path.
  function automatic logic [31:0] l_data(input logic [31:0] t);
    return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
  endfunction

  // Linear transform of the key schedule.
  function automatic logic [31:0] l_key(input logic [31:0] t);
    return t ^ rotl(t, 13) ^ rotl(t, 23);
  endfunction

  // Round constant: byte j of round i is (4i + j) * 7 modulo 256.
  function automatic logic [31:0] ck_word(input logic [7:0] i);
    logic [31:0] w;
    logic [7:0]  base;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      base = {i[5:0], 2'b00} + 8'(j);
      w = {w[23:0], 8'((base << 3) - base)};
    end
    return w;
  endfunction

  // One data round on the state {X0, X1, X2, X3}, X0 in the top word.
  function automatic logic [127:0] round_f(input logic [127:0] s, input logic [31:0] rk);
    logic [31:0] t;
    t = tau(s[95:64] ^ s[63:32] ^ s[31:0] ^ rk);
    return {s[95:0], s[127:96] ^ l_data(t)};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sm4_block_cipher.sv -----
// SM4 block cipher: 32-stage round pipeline with a two-entry output buffer.
// An accepted request passes the input and round stage registers into the output buffer.
// Throughput: one block per cycle outside key expansion; the round pipeline stalls only
// when the buffer is full. Reset clears the key registers and starts key expansion, which
// runs again after every key write; s_tready stays low while it runs.
`default_nettype none

module sm4_block_cipher
  import sm4_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  // Input stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // [63:0] block_high, [127:64] block_low
  input  wire logic [0:0]   s_tuser,  // [0] opcode
  // Output stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata   // [63:0] result_high, [127:64] result_low
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         ks_start;
  logic         ks_busy;
  logic [31:0]  round_key [ROUNDS];

  logic         v   [ROUNDS];
  logic         op  [ROUNDS];
  logic [127:0] st  [ROUNDS];
  logic [31:0]  rk_sel [ROUNDS];

  logic [1:0]   count;
  logic [1:0]   count_next;
  logic [127:0] head;
  logic [127:0] spare;
  logic [127:0] fin;
  logic         adv;
  logic         push;
  logic         pop;

  // Key registers; a write restarts key expansion on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      ks_start <= 1'b1;
    end else begin
      ks_start <= cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
      if (cfg_we && cfg_index == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end
    end
  end

  sm4_key_sched #(
    .ROUNDS(ROUNDS)
  ) u_key_sched (
    .clk      (clk),
    .rst      (rst),
    .start    (ks_start),
    .key_high (key_high),
    .key_low  (key_low),
    .busy     (ks_busy),
    .round_key(round_key)
  );

  // The pipeline moves as a whole while the output buffer has room.
  assign adv      = (count != 2'd2);
  assign s_tready = adv && !ks_busy;

  // Each stage picks its round key by the request's operation.
  always_comb begin
    for (int i = 0; i < ROUNDS; i++) begin
      rk_sel[i] = op[i] ? round_key[ROUNDS - 1 - i] : round_key[i];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROUNDS; i++) begin
        v[i] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= s_tvalid && s_tready;
      for (int i = 1; i < ROUNDS; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // Stage payload: the input register, then one round per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {s_tdata[63:0], s_tdata[127:64]};
      op[0] <= s_tuser[0];
      for (int i = 1; i < ROUNDS; i++) begin
        st[i] <= round_f(st[i-1], rk_sel[i-1]);
        op[i] <= op[i-1];
      end
    end
  end

  // Last round and reordering into X35, X34, X33, X32.
  always_comb begin
    logic [127:0] s;
    s   = round_f(st[ROUNDS-1], rk_sel[ROUNDS-1]);
    fin = {s[31:0], s[63:32], s[95:64], s[127:96]};
  end

  // Output buffer control.
  assign push = adv && v[ROUNDS-1];
  assign pop  = m_tvalid && m_tready;

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output buffer data: head drives the port, spare catches one more result.
  always_ff @(posedge clk) begin
    if (count == 2'd2 && pop) begin
      head <= spare;
    end else if (push && (count == 2'd0 || pop)) begin
      head <= fin;
    end
    if (push && count == 2'd1 && !pop) begin
      spare <= fin;
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {head[63:0], head[127:64]};

`include "sm4_block_cipher_assert.svh"

  `SM4_ASSERT_ALWAYS(a_buf_count, count != 2'd3, "output buffer count overflow")
  `SM4_ASSERT_IMPL(a_no_push_full, count == 2'd2, !push, "result pushed into full buffer")
  `SM4_ASSERT_IMPL(a_no_req_busy, s_tready, !ks_busy, "request taken during key expansion")

endmodule

`default_nettype wire

// ----- rtl/core/sm4_key_sched.sv -----
// Iterative key expansion: one round key per cycle into a register bank.
`default_nettype none

module sm4_key_sched
  import sm4_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  output logic             busy,
  output logic [31:0]      round_key [ROUNDS]
);

  localparam int CW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [31:0]   k [4];
  logic [31:0]   nk;

  // Next key word from the current window of four.
  assign nk = k[0] ^ l_key(tau(k[1] ^ k[2] ^ k[3] ^ ck_word(8'(cnt))));

  assign busy = running | start;

  // Sequencer: a start reloads the window, then one round each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        running <= 1'b0;
      end
    end
  end

  // Key window and round key bank.
  always_ff @(posedge clk) begin
    if (start) begin
      k[0] <= key_high[63:32] ^ FK[0];
      k[1] <= key_high[31:0] ^ FK[1];
      k[2] <= key_low[63:32] ^ FK[2];
      k[3] <= key_low[31:0] ^ FK[3];
    end else if (running) begin
      k[0]           <= k[1];
      k[1]           <= k[2];
      k[2]           <= k[3];
      k[3]           <= nk;
      round_key[cnt] <= nk;
    end
  end

`include "sm4_block_cipher_assert.svh"

  `SM4_ASSERT_IMPL(a_ks_full_run, $fell(running), $past(cnt) == LAST, "key expansion ended early")

endmodule

`default_nettype wire
